FILE: rtl/tvm_pkg.sv
// shared types, codes and defaults of the tagged register vm execute block
`default_nettype none

package tvm_pkg;

  // default store depths
  localparam int NUM_REGISTERS = 256;
  localparam int NUM_VARIABLES = 256;

  // field widths fixed by the instruction format
  localparam int KIND_W    = 4;
  localparam int IDX_W     = 8;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int LUT_DEPTH = 1 << IDX_W;

  typedef logic [1:0]          tag_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  // entry tags
  localparam tag_t TAG_EMPTY = 2'd0;
  localparam tag_t TAG_INT   = 2'd1;
  localparam tag_t TAG_REF   = 2'd2;

  // instruction kinds
  localparam kind_t KIND_READ_VAR = 4'd0;
  localparam kind_t KIND_REF_VAR  = 4'd1;
  localparam kind_t KIND_LOAD_IMM = 4'd2;
  localparam kind_t KIND_ASSIGN   = 4'd3;
  localparam kind_t KIND_RETURN   = 4'd4;
  localparam kind_t KIND_ADD      = 4'd5;
  localparam kind_t KIND_MUL      = 4'd6;
  localparam kind_t KIND_NEG      = 4'd7;
  localparam kind_t KIND_PLUS     = 4'd8;
  localparam kind_t KIND_NOT      = 4'd9;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RET   = 2'd1;
  localparam status_t ST_TYPE  = 2'd2;
  localparam status_t ST_UNSUP = 2'd3;

  // one tagged store entry
  typedef struct packed {
    tag_t              tag;
    logic [DATA_W-1:0] payload;
  } entry_t;

  // write and flash-clear control of one store
  typedef struct packed {
    logic we;
    logic clr;
  } mem_ctl_t;

  // outcome of executing one instruction
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] ret_val;
    logic              reg_we;
    entry_t            reg_data;
    logic              var_we;
    logic              clr;
  } exec_res_t;

endpackage

`default_nettype wire

FILE: rtl/tvm_regfile.sv
// tagged register file: two registered read ports, one write port, flash-clear valid bits
`default_nettype none

module tvm_regfile #(
  parameter  int NumRegs = tvm_pkg::NUM_REGISTERS,
  localparam int IdxW    = $clog2(NumRegs)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [IdxW-1:0]   rd0_addr_i,
  input  wire logic [IdxW-1:0]   rd1_addr_i,
  output tvm_pkg::entry_t        rd0_data_o,
  output tvm_pkg::entry_t        rd1_data_o,
  input  tvm_pkg::mem_ctl_t      ctl_i,
  input  wire logic [IdxW-1:0]   wr_addr_i,
  input  tvm_pkg::entry_t        wr_data_i
);

  tvm_pkg::entry_t      mem_q [NumRegs];
  tvm_pkg::entry_t      rd0_q, rd1_q;
  logic                 vld0_q, vld1_q;
  logic [NumRegs-1:0]   valid_q, valid_d;

  // next valid bits: flash clear or set on write
  always_comb begin
    valid_d = ctl_i.clr ? '0 : valid_q;
    if (ctl_i.we) begin
      valid_d[wr_addr_i] = 1'b1;
    end
  end

  // valid bits and registered valid of each read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld0_q  <= 1'b0;
      vld1_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        vld0_q <= valid_d[rd0_addr_i];
        vld1_q <= valid_d[rd1_addr_i];
      end
    end
  end

  // storage array with write-first bypass on the read ports
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd0_q <= (ctl_i.we && (wr_addr_i == rd0_addr_i)) ? wr_data_i : mem_q[rd0_addr_i];
      rd1_q <= (ctl_i.we && (wr_addr_i == rd1_addr_i)) ? wr_data_i : mem_q[rd1_addr_i];
    end
  end

  // entries not valid read as empty
  assign rd0_data_o = vld0_q ? rd0_q : '0;
  assign rd1_data_o = vld1_q ? rd1_q : '0;

endmodule

`default_nettype wire

FILE: rtl/tvm_varstore.sv
// tagged variable store: one registered read port, one write port, flash-clear valid bits
`default_nettype none

module tvm_varstore #(
  parameter  int NumVars = tvm_pkg::NUM_VARIABLES,
  localparam int VarW    = $clog2(NumVars)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [VarW-1:0]   rd_addr_i,
  output tvm_pkg::entry_t        rd_data_o,
  input  tvm_pkg::mem_ctl_t      ctl_i,
  input  wire logic [VarW-1:0]   wr_addr_i,
  input  tvm_pkg::entry_t        wr_data_i
);

  tvm_pkg::entry_t      mem_q [NumVars];
  tvm_pkg::entry_t      rd_q;
  logic                 vld_q;
  logic [NumVars-1:0]   valid_q, valid_d;

  // next valid bits: flash clear or set on write
  always_comb begin
    valid_d = ctl_i.clr ? '0 : valid_q;
    if (ctl_i.we) begin
      valid_d[wr_addr_i] = 1'b1;
    end
  end

  // valid bits and registered valid of the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        vld_q <= valid_d[rd_addr_i];
      end
    end
  end

  // storage array with write-first bypass
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= (ctl_i.we && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  // entries not valid read as empty
  assign rd_data_o = vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/tvm_exec.sv
// instruction execute logic: type checks, arithmetic and write-back decisions
`default_nettype none

module tvm_exec (
  input  tvm_pkg::kind_t                    kind_i,
  input  tvm_pkg::entry_t                   src_x_i,
  input  tvm_pkg::entry_t                   src_y_i,
  input  tvm_pkg::entry_t                   var_i,
  input  wire logic [tvm_pkg::DATA_W-1:0]   imm_i,
  input  wire logic [tvm_pkg::DATA_W-1:0]   ref_payload_i,
  output tvm_pkg::exec_res_t                res_o
);

  logic x_int, y_int, y_ref;

  assign x_int = (src_x_i.tag == tvm_pkg::TAG_INT);
  assign y_int = (src_y_i.tag == tvm_pkg::TAG_INT);
  assign y_ref = (src_y_i.tag == tvm_pkg::TAG_REF);

  // decode and execute
  always_comb begin
    res_o                  = '0;
    res_o.status           = tvm_pkg::ST_OK;
    res_o.reg_data.tag     = tvm_pkg::TAG_INT;
    res_o.reg_data.payload = src_x_i.payload;
    case (kind_i)
      tvm_pkg::KIND_READ_VAR: begin
        res_o.reg_we   = 1'b1;
        res_o.reg_data = var_i;
      end
      tvm_pkg::KIND_REF_VAR: begin
        res_o.reg_we           = 1'b1;
        res_o.reg_data.tag     = tvm_pkg::TAG_REF;
        res_o.reg_data.payload = ref_payload_i;
      end
      tvm_pkg::KIND_LOAD_IMM: begin
        res_o.reg_we           = 1'b1;
        res_o.reg_data.payload = imm_i;
      end
      tvm_pkg::KIND_ASSIGN: begin
        // second port holds the register with the reference
        if (y_ref) begin
          res_o.var_we = 1'b1;
        end else begin
          res_o.status = tvm_pkg::ST_TYPE;
        end
      end
      tvm_pkg::KIND_RETURN: begin
        if (x_int) begin
          res_o.status  = tvm_pkg::ST_RET;
          res_o.ret_val = src_x_i.payload;
        end else begin
          res_o.status = tvm_pkg::ST_TYPE;
        end
      end
      tvm_pkg::KIND_ADD, tvm_pkg::KIND_MUL: begin
        if (x_int && y_int) begin
          res_o.reg_we = 1'b1;
          if (kind_i == tvm_pkg::KIND_ADD) begin
            res_o.reg_data.payload = src_x_i.payload + src_y_i.payload;
          end else begin
            res_o.reg_data.payload = src_x_i.payload * src_y_i.payload;
          end
        end else begin
          res_o.status = tvm_pkg::ST_TYPE;
        end
      end
      tvm_pkg::KIND_NEG, tvm_pkg::KIND_PLUS, tvm_pkg::KIND_NOT: begin
        if (x_int) begin
          res_o.reg_we = 1'b1;
          if (kind_i == tvm_pkg::KIND_NEG) begin
            res_o.reg_data.payload = '0 - src_x_i.payload;
          end else if (kind_i == tvm_pkg::KIND_NOT) begin
            res_o.reg_data.payload = {{(tvm_pkg::DATA_W-1){1'b0}}, (src_x_i.payload == '0)};
          end
        end else begin
          res_o.status = tvm_pkg::ST_TYPE;
        end
      end
      default: begin
        // unassigned kinds
        res_o.status = tvm_pkg::ST_UNSUP;
      end
    endcase
    // any non-ok result starts a new program
    res_o.clr = (res_o.status != tvm_pkg::ST_OK);
  end

endmodule

`default_nettype wire

FILE: rtl/tagged_register_vm_execute_top.sv
// top level of the tagged register vm execute block
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | request   | in_valid_i / in_ready_o | kind, dest/src_a/src_b index, immediate
//  out     | result    | out_valid_o/out_ready_i | status, return_value
//
// one instruction per cycle while the output is not held; the request is registered with the store read at
// accept, then executed, written back and registered into the output register, where its result becomes valid.
// same-entry accesses of adjacent instructions are covered by write-first bypass in the stores.
// reset clears all valid bits of both stores at once; no clearing pass is needed.
// a held output stalls the execute stage; in_ready_o drops only while that stage is full.
`default_nettype none

module tagged_register_vm_execute_top #(
  parameter int NumRegs = tvm_pkg::NUM_REGISTERS,
  parameter int NumVars = tvm_pkg::NUM_VARIABLES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [tvm_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [tvm_pkg::IDX_W-1:0]           dest_index_i,
  input  wire logic [tvm_pkg::IDX_W-1:0]           src_a_index_i,
  input  wire logic [tvm_pkg::IDX_W-1:0]           src_b_index_i,
  input  wire logic signed [tvm_pkg::DATA_W-1:0]   immediate_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [tvm_pkg::STATUS_W-1:0]             status_o,
  output logic signed [tvm_pkg::DATA_W-1:0]        return_value_o
);

  localparam int IdxW = $clog2(NumRegs);
  localparam int VarW = $clog2(NumVars);

  // index reduction tables
  logic [IdxW-1:0] reg_lut [tvm_pkg::LUT_DEPTH];
  logic [VarW-1:0] var_lut [tvm_pkg::LUT_DEPTH];

  for (genvar g = 0; g < tvm_pkg::LUT_DEPTH; g++) begin : g_lut
    assign reg_lut[g] = IdxW'(g % NumRegs);
    assign var_lut[g] = VarW'(g % NumVars);
  end

  logic                         accept, s1_fire;
  logic                         s1_vld_q;
  tvm_pkg::kind_t               kind_q;
  logic [IdxW-1:0]              dst_q;
  logic [VarW-1:0]              ref_q;
  logic [tvm_pkg::DATA_W-1:0]   imm_q;
  logic                         out_vld_q;
  tvm_pkg::status_t             status_q;
  logic [tvm_pkg::DATA_W-1:0]   rv_q;

  tvm_pkg::entry_t              src_x, src_y, var_rd;
  tvm_pkg::exec_res_t           res;
  tvm_pkg::mem_ctl_t            reg_ctl, var_ctl;
  logic [IdxW-1:0]              rd1_addr;

  // handshake
  assign s1_fire    = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;

  // second register port reads the reference holder for assign
  assign rd1_addr = (kind_i == tvm_pkg::KIND_ASSIGN) ? reg_lut[dest_index_i]
                                                     : reg_lut[src_b_index_i];

  // store controls, only when the execute stage retires
  always_comb begin
    reg_ctl.we  = s1_fire && res.reg_we;
    reg_ctl.clr = s1_fire && res.clr;
    var_ctl.we  = s1_fire && res.var_we;
    var_ctl.clr = s1_fire && res.clr;
  end

  tvm_regfile #(
    .NumRegs (NumRegs)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd0_addr_i (reg_lut[src_a_index_i]),
    .rd1_addr_i (rd1_addr),
    .rd0_data_o (src_x),
    .rd1_data_o (src_y),
    .ctl_i      (reg_ctl),
    .wr_addr_i  (dst_q),
    .wr_data_i  (res.reg_data)
  );

  tvm_varstore #(
    .NumVars (NumVars)
  ) u_varstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (var_lut[src_a_index_i]),
    .rd_data_o (var_rd),
    .ctl_i     (var_ctl),
    .wr_addr_i (src_y.payload[VarW-1:0]),
    .wr_data_i (src_x)
  );

  tvm_exec u_exec (
    .kind_i        (kind_q),
    .src_x_i       (src_x),
    .src_y_i       (src_y),
    .var_i         (var_rd),
    .imm_i         (imm_q),
    .ref_payload_i (tvm_pkg::DATA_W'(ref_q)),
    .res_o         (res)
  );

  // execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  // execute stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      dst_q  <= reg_lut[dest_index_i];
      ref_q  <= var_lut[src_a_index_i];
      imm_q  <= immediate_i;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q <= res.status;
      rv_q     <= res.ret_val;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign return_value_o = $signed(rv_q);

endmodule

`default_nettype wire
